>>> hw/rtl/tiexu_pkg.sv
// Types and constants shared by the toy ISA execute unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps

package tiexu_pkg;

  localparam int XLEN       = 64;
  localparam int REG_IDX_W  = 6;
  localparam int DBU_W      = 13;
  localparam int STEP_W     = 32;
  localparam int LOAD_BYTES = 8;

  localparam logic [1:0] CFG_ENTRY_PC   = 2'd0;
  localparam logic [1:0] CFG_STEP_LIMIT = 2'd1;
  localparam logic [1:0] CFG_DATA_BYTES = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_LI      = 4'd1,
    OP_ADD     = 4'd2,
    OP_XOR     = 4'd3,
    OP_LD      = 4'd4,
    OP_ST      = 4'd5,
    OP_J       = 4'd6,
    OP_BEQ     = 4'd7,
    OP_CALL    = 4'd8,
    OP_RET     = 4'd9,
    OP_HALT    = 4'd10,
    OP_SYSCALL = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_BAD_PC  = 3'd2,
    ST_BAD_MEM = 3'd3,
    ST_BAD_OP  = 3'd4,
    ST_STEPS   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_READ,
    BS_EXEC,
    BS_LOAD
  } bstate_e;

  typedef struct packed {
    op_e                  op;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
    logic [XLEN-1:0]      imm;
    logic                 illegal;
  } instr_t;

  typedef struct packed {
    status_e         status;
    logic [XLEN-1:0] pc;
    logic            syscall_seen;
    logic [XLEN-1:0] syscall_number;
  } result_t;

  typedef struct packed {
    logic              entry_we;
    logic [XLEN-1:0]   entry_val;
    logic [STEP_W-1:0] step_max;
    logic [DBU_W-1:0]  data_bytes_used;
  } cfg_t;

endpackage

>>> hw/rtl/toy_isa_execute_unit.sv
// Toy ISA execute unit: the back end reads a request's registers (BS_READ), executes it
// (BS_EXEC) and, for a load, reads data memory (BS_LOAD), then writes the result register;
// it takes the next request only once the current one completes. Reset is asynchronous,
// active low; after reset a clear sweep zeroes the data
// memory while no request is accepted. Configuration registers on an APB-style port.
`timescale 1ns / 1ps

module toy_isa_execute_unit #(
  parameter int NUM_REGS    = 32,
  parameter int MEM_BYTES   = 4096,
  parameter int INSTR_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [3:0]                      op_i,
  input  logic [tiexu_pkg::REG_IDX_W-1:0] dest_reg_i,
  input  logic [tiexu_pkg::REG_IDX_W-1:0] src_reg_a_i,
  input  logic [tiexu_pkg::REG_IDX_W-1:0] src_reg_b_i,
  input  logic [tiexu_pkg::XLEN-1:0]      immediate_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [tiexu_pkg::XLEN-1:0]      pc_out_o,
  output logic                            syscall_seen_o,
  output logic [tiexu_pkg::XLEN-1:0]      syscall_number_o
);
  import tiexu_pkg::*;

  logic [XLEN-1:0]   entry_q;
  logic [STEP_W-1:0] step_q;
  logic [DBU_W-1:0]  dbu_q;
  logic              cfg_we;
  cfg_t              cfg;
  logic              head_valid, pop, clearing;
  instr_t            head;
  result_t           res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      step_q  <= '1;
      dbu_q   <= DBU_W'(4096);
    end else if (cfg_we) begin
      case (paddr[4:3])
        CFG_ENTRY_PC:   entry_q <= pwdata;
        CFG_STEP_LIMIT: step_q  <= pwdata[STEP_W-1:0];
        CFG_DATA_BYTES: dbu_q   <= pwdata[DBU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      CFG_ENTRY_PC:   prdata = entry_q;
      CFG_STEP_LIMIT: prdata = 64'(step_q);
      CFG_DATA_BYTES: prdata = 64'(dbu_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg.entry_we        = cfg_we && (paddr[4:3] == CFG_ENTRY_PC);
  assign cfg.entry_val       = pwdata;
  assign cfg.step_max        = step_q;
  assign cfg.data_bytes_used = dbu_q;

  tiexu_front #(.NUM_REGS(NUM_REGS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .dest_reg_i   (dest_reg_i),
    .src_reg_a_i  (src_reg_a_i),
    .src_reg_b_i  (src_reg_b_i),
    .immediate_i  (immediate_i),
    .hold_i       (clearing),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  tiexu_back #(
    .NUM_REGS    (NUM_REGS),
    .MEM_BYTES   (MEM_BYTES),
    .INSTR_BYTES (INSTR_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign status_o         = res.status;
  assign pc_out_o         = res.pc;
  assign syscall_seen_o   = res.syscall_seen;
  assign syscall_number_o = res.syscall_number;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o) else $error("request accepted during clear sweep");
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o) else $error("result present during clear sweep");
  a_trap_no_syscall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (!syscall_seen_o && syscall_number_o == '0))
    else $error("syscall fields set on a trapped result");
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid) else $error("queue popped while empty");
`endif

endmodule

>>> hw/rtl/tiexu_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on tiexu_pkg.
`timescale 1ns / 1ps

module tiexu_front #(
  parameter int NUM_REGS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [3:0]                      op_i,
  input  logic [tiexu_pkg::REG_IDX_W-1:0] dest_reg_i,
  input  logic [tiexu_pkg::REG_IDX_W-1:0] src_reg_a_i,
  input  logic [tiexu_pkg::REG_IDX_W-1:0] src_reg_b_i,
  input  logic [tiexu_pkg::XLEN-1:0]      immediate_i,
  input  logic                            hold_i,
  output logic                            head_valid_o,
  output tiexu_pkg::instr_t               head_o,
  input  logic                            pop_i
);
  import tiexu_pkg::*;

  localparam logic [REG_IDX_W:0] NREG = (REG_IDX_W+1)'(NUM_REGS);

  instr_t     dec;
  logic       ok_rd, ok_ra, ok_rb;
  instr_t     slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign ok_rd = {1'b0, dest_reg_i}  < NREG;
  assign ok_ra = {1'b0, src_reg_a_i} < NREG;
  assign ok_rb = {1'b0, src_reg_b_i} < NREG;

  always_comb begin
    dec.op  = op_e'(op_i);
    dec.rd  = dest_reg_i;
    dec.ra  = src_reg_a_i;
    dec.rb  = src_reg_b_i;
    dec.imm = immediate_i;
    case (op_e'(op_i))
      OP_NOP, OP_J, OP_CALL, OP_RET, OP_HALT, OP_SYSCALL: dec.illegal = 1'b0;
      OP_LI:          dec.illegal = !ok_rd;
      OP_ADD, OP_XOR: dec.illegal = !(ok_rd && ok_ra && ok_rb);
      OP_LD:          dec.illegal = !(ok_rd && ok_ra);
      OP_ST, OP_BEQ:  dec.illegal = !(ok_ra && ok_rb);
      default:        dec.illegal = 1'b1;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2) && !hold_i;
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

>>> hw/rtl/tiexu_back.sv
// Back end: register file, banked data memory with clear sweep, execution and result register.
// Depends on tiexu_pkg.
`timescale 1ns / 1ps

module tiexu_back #(
  parameter int NUM_REGS    = 32,
  parameter int MEM_BYTES   = 4096,
  parameter int INSTR_BYTES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tiexu_pkg::cfg_t      cfg_i,
  input  logic                 head_valid_i,
  input  tiexu_pkg::instr_t    head_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tiexu_pkg::result_t   out_o
);
  import tiexu_pkg::*;

  localparam int ROWS   = (MEM_BYTES + 7) / 8;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = ROW_W + 3;
  localparam int REG_W  = $clog2(NUM_REGS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  bstate_e state_q, state_d;

  logic [XLEN-1:0]   rf_q [NUM_REGS];
  logic [NUM_REGS-1:0] rv_q;
  logic [XLEN-1:0]   rda_q, rdb_q;
  logic [REG_W-1:0]  ra_idx, rb_idx, rf_wa;
  logic              rf_we;
  logic [XLEN-1:0]   rf_wd;

  logic [XLEN-1:0]   pc_q;
  logic [STEP_W-1:0] retired_q;
  logic              stopped_q;
  status_e           stop_status_q;
  logic [ROW_W-1:0]  clr_row_q;

  logic              out_valid_q;
  result_t           out_q, res;
  logic              out_free, complete, retire, trap, ld_issue, st_we;
  status_e           trap_st;
  logic [XLEN-1:0]   next_pc;

  logic [XLEN+1:0]   ms, ts;
  logic [XLEN-1:0]   size64, pcn;
  logic              mem_ok, pcr_ok, step_hit, load_ok;
  logic [ADDR_W-1:0] addr;
  logic [2:0]        a0_q;
  logic [7:0]        ld_q [8];
  logic [XLEN-1:0]   ld_val;
  logic [ROW_W-1:0]  bank_row [8];
  logic [7:0]        bank_wd [8];
  logic              bank_we;

  assign out_free   = !out_valid_q || out_ready_i;
  assign clearing_o = state_q == BS_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign size64 = (64'(cfg_i.data_bytes_used) > 64'(MEM_BYTES)) ? 64'(MEM_BYTES)
                                                                : 64'(cfg_i.data_bytes_used);
  assign ms     = {2'b00, rda_q} + {{2{head_i.imm[XLEN-1]}}, head_i.imm};
  assign mem_ok = (ms[XLEN+1:XLEN] == 2'b00) && (size64 >= 64'd8)
                  && (ms[XLEN-1:0] <= size64 - 64'd8);
  assign pcn    = pc_q + 64'(INSTR_BYTES);
  assign ts     = {2'b00, pcn} + {{2{head_i.imm[XLEN-1]}}, head_i.imm};
  assign pcr_ok = ts[XLEN+1:XLEN] == 2'b00;
  assign step_hit = retired_q >= cfg_i.step_max;
  assign addr   = ms[ADDR_W-1:0];
  assign load_ok = !stopped_q && !step_hit && !head_i.illegal && (head_i.op == OP_LD) && mem_ok;

  assign ra_idx = (head_i.op == OP_RET) ? REG_W'(1) : head_i.ra[REG_W-1:0];
  assign rb_idx = head_i.rb[REG_W-1:0];

  always_comb begin
    for (int i = 0; i < LOAD_BYTES; i++) begin
      ld_val[8*i +: 8] = ld_q[3'(a0_q + 3'(i))];
    end
  end

  // bank k holds bytes whose address is k modulo eight
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      logic [2:0] lane;
      lane = 3'(3'(k) - addr[2:0]);
      if (clearing_o) begin
        bank_row[k] = clr_row_q;
        bank_wd[k]  = 8'd0;
      end else begin
        bank_row[k] = ROW_W'((addr + ADDR_W'(lane)) >> 3);
        bank_wd[k]  = rdb_q[8*lane +: 8];
      end
    end
  end
  assign bank_we = clearing_o || st_we;

  for (genvar k = 0; k < 8; k++) begin : g_bank
    logic [7:0] mem_q [ROWS];
    always_ff @(posedge clk_i) begin
      if (bank_we) mem_q[bank_row[k]] <= bank_wd[k];
      if (ld_issue) ld_q[k] <= mem_q[bank_row[k]];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_CLEAR: if (clr_row_q == LAST_ROW) state_d = BS_READ;
      BS_READ:  if (head_valid_i) state_d = BS_EXEC;
      BS_EXEC: begin
        if (load_ok) state_d = BS_LOAD;
        else if (out_free) state_d = BS_READ;
      end
      BS_LOAD:  if (out_free) state_d = BS_READ;
      default:  state_d = BS_CLEAR;
    endcase
  end

  always_comb begin
    complete = 1'b0;
    retire   = 1'b0;
    trap     = 1'b0;
    trap_st  = ST_OK;
    ld_issue = 1'b0;
    st_we    = 1'b0;
    rf_we    = 1'b0;
    rf_wa    = head_i.rd[REG_W-1:0];
    rf_wd    = head_i.imm;
    next_pc  = pcn;
    res      = '{status: ST_OK, pc: pc_q, syscall_seen: 1'b0, syscall_number: '0};
    case (state_q)
      BS_EXEC: begin
        if (stopped_q) begin
          res.status = stop_status_q;
        end else if (step_hit) begin
          trap = 1'b1; trap_st = ST_STEPS;
        end else if (head_i.illegal) begin
          trap = 1'b1; trap_st = ST_BAD_OP;
        end else begin
          case (head_i.op)
            OP_LI:  rf_we = 1'b1;
            OP_ADD: begin rf_we = 1'b1; rf_wd = rda_q + rdb_q; end
            OP_XOR: begin rf_we = 1'b1; rf_wd = rda_q ^ rdb_q; end
            OP_LD: begin
              if (mem_ok) ld_issue = 1'b1;
              else begin trap = 1'b1; trap_st = ST_BAD_MEM; end
            end
            OP_ST: begin
              if (mem_ok) st_we = out_free;
              else begin trap = 1'b1; trap_st = ST_BAD_MEM; end
            end
            OP_J: begin
              if (pcr_ok) next_pc = ts[XLEN-1:0];
              else begin trap = 1'b1; trap_st = ST_BAD_PC; end
            end
            OP_BEQ: begin
              if (rda_q == rdb_q) begin
                if (pcr_ok) next_pc = ts[XLEN-1:0];
                else begin trap = 1'b1; trap_st = ST_BAD_PC; end
              end
            end
            OP_CALL: begin
              if (pcr_ok) begin
                next_pc = ts[XLEN-1:0];
                rf_we   = 1'b1;
                rf_wa   = REG_W'(1);
                rf_wd   = pcn;
              end else begin
                trap = 1'b1; trap_st = ST_BAD_PC;
              end
            end
            OP_RET:  next_pc = rda_q;
            OP_HALT: begin trap = 1'b1; trap_st = ST_HALT; end
            OP_SYSCALL: begin
              res.syscall_seen   = 1'b1;
              res.syscall_number = head_i.imm;
            end
            OP_NOP:  ;
            default: begin trap = 1'b1; trap_st = ST_BAD_OP; end
          endcase
          if (trap) begin
            res.status         = trap_st;
            res.syscall_seen   = 1'b0;
            res.syscall_number = '0;
          end else begin
            res.pc = next_pc;
          end
        end
        if (trap) res.status = trap_st;
        retire   = !stopped_q && !trap && !ld_issue && out_free;
        complete = !ld_issue && out_free;
        trap     = trap && out_free;
        rf_we    = rf_we && retire && (rf_wa != '0);
      end
      BS_LOAD: begin
        res.pc   = pcn;
        complete = out_free;
        retire   = out_free;
        rf_wd    = ld_val;
        rf_we    = out_free && (rf_wa != '0);
      end
      default: ;
    endcase
  end

  assign pop_o = complete;

  always_ff @(posedge clk_i) begin
    if (state_q == BS_READ) begin
      rda_q <= (ra_idx != '0 && rv_q[ra_idx]) ? rf_q[ra_idx] : '0;
      rdb_q <= (rb_idx != '0 && rv_q[rb_idx]) ? rf_q[rb_idx] : '0;
    end
    if (rf_we) rf_q[rf_wa] <= rf_wd;
    if (ld_issue) a0_q <= addr[2:0];
    if (complete) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BS_CLEAR;
      clr_row_q     <= '0;
      rv_q          <= '0;
      pc_q          <= '0;
      retired_q     <= '0;
      stopped_q     <= 1'b0;
      stop_status_q <= ST_OK;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing_o) clr_row_q <= clr_row_q + ROW_W'(1);
      if (rf_we) rv_q[rf_wa] <= 1'b1;
      if (cfg_i.entry_we && retired_q == '0 && !stopped_q) pc_q <= cfg_i.entry_val;
      else if (retire) pc_q <= res.pc;
      if (retire) retired_q <= retired_q + STEP_W'(1);
      if (trap) begin
        stopped_q     <= 1'b1;
        stop_status_q <= trap_st;
      end
      if (complete) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

>>> bench/testbench.sv
// Self-checking bench for toy_isa_execute_unit: valid/ready instruction requests,
// an APB-style configuration port, and a cycle-free predictor of the architectural state.
// Depends on tiexu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
  import tiexu_pkg::*;

  localparam int MEMSZ    = 4096;
  localparam int NREG     = 32;
  localparam int ISTEP    = 8;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [3:0]  op;
    logic [5:0]  rd;
    logic [5:0]  ra;
    logic [5:0]  rb;
    logic [63:0] imm;
  } instr_req_t;

  typedef struct {
    status_e     st;
    logic [63:0] pc;
    logic        sys;
    logic [63:0] num;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [3:0]  op_i = '0;
  logic [5:0]  dest_reg_i = '0, src_reg_a_i = '0, src_reg_b_i = '0;
  logic [63:0] immediate_i = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] pc_out_o;
  logic        syscall_seen_o;
  logic [63:0] syscall_number_o;

  logic [63:0] cpu_pc;
  logic [63:0] regs [NREG];
  logic [7:0]  dmem [MEMSZ];
  logic [31:0] retired;
  bit          halted;
  status_e     halt_st;
  logic [63:0] cfg_entry;
  logic [31:0] cfg_limit;
  logic [12:0] cfg_dbu;

  outcome_t results_q [$];
  int       mismatches, n_sent, n_checked, n_sys, n_trap_kind, quiet;
  bit       hold_rx, no_idle;

  toy_isa_execute_unit dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .op_i(op_i), .dest_reg_i(dest_reg_i), .src_reg_a_i(src_reg_a_i),
    .src_reg_b_i(src_reg_b_i), .immediate_i(immediate_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready),
    .status_o(status_o), .pc_out_o(pc_out_o), .syscall_seen_o(syscall_seen_o),
    .syscall_number_o(syscall_number_o)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] rd_reg(logic [5:0] idx);
    return (idx == 0 || idx >= NREG) ? 64'd0 : regs[idx];
  endfunction

  function automatic bit mem_window(logic [63:0] base, logic [63:0] imm,
                                    output int unsigned addr);
    logic signed [65:0] s;
    logic signed [65:0] lim;
    int unsigned sz;
    sz = (cfg_dbu > MEMSZ) ? MEMSZ : cfg_dbu;
    s = $signed({2'b00, base}) + $signed({{2{imm[63]}}, imm});
    lim = sz;
    lim = lim - 8;
    addr = s[31:0];
    return sz >= 8 && !s[65] && s <= lim;
  endfunction

  function automatic bit pc_target(logic [63:0] nxt, logic [63:0] imm, output logic [63:0] t);
    logic signed [65:0] s;
    s = $signed({2'b00, nxt}) + $signed({{2{imm[63]}}, imm});
    t = s[63:0];
    return s[65:64] == 2'b00;
  endfunction

  function automatic outcome_t execute(instr_req_t r, bit commit);
    outcome_t    o;
    logic [63:0] nxt, t, v;
    int unsigned a;
    status_e     st;
    bit          sys, wr, do_st;
    logic [5:0]  wr_idx;
    logic [63:0] wr_val;
    o.sys = 1'b0;
    o.num = '0;
    if (halted) begin
      o.st = halt_st;
      o.pc = cpu_pc;
      return o;
    end
    nxt = cpu_pc + ISTEP;
    st = ST_OK;
    sys = 0; wr = 0; do_st = 0; wr_idx = '0; wr_val = '0; v = '0; a = 0;
    if (retired >= cfg_limit) st = ST_STEPS;
    else case (r.op)
      OP_NOP: ;
      OP_LI: if (r.rd >= NREG) st = ST_BAD_OP;
             else begin wr = 1; wr_idx = r.rd; wr_val = r.imm; end
      OP_ADD, OP_XOR: begin
        if (r.rd >= NREG || r.ra >= NREG || r.rb >= NREG) st = ST_BAD_OP;
        else begin
          wr = 1; wr_idx = r.rd;
          wr_val = (r.op == OP_ADD) ? rd_reg(r.ra) + rd_reg(r.rb) : rd_reg(r.ra) ^ rd_reg(r.rb);
        end
      end
      OP_LD: begin
        if (r.rd >= NREG || r.ra >= NREG) st = ST_BAD_OP;
        else if (!mem_window(rd_reg(r.ra), r.imm, a)) st = ST_BAD_MEM;
        else begin
          for (int i = 0; i < 8; i++) v[8*i +: 8] = dmem[a + i];
          wr = 1; wr_idx = r.rd; wr_val = v;
        end
      end
      OP_ST: begin
        if (r.rb >= NREG || r.ra >= NREG) st = ST_BAD_OP;
        else if (!mem_window(rd_reg(r.ra), r.imm, a)) st = ST_BAD_MEM;
        else do_st = 1;
      end
      OP_J: if (!pc_target(nxt, r.imm, t)) st = ST_BAD_PC; else nxt = t;
      OP_BEQ: begin
        if (r.ra >= NREG || r.rb >= NREG) st = ST_BAD_OP;
        else if (rd_reg(r.ra) == rd_reg(r.rb)) begin
          if (!pc_target(nxt, r.imm, t)) st = ST_BAD_PC; else nxt = t;
        end
      end
      OP_CALL: begin
        if (!pc_target(nxt, r.imm, t)) st = ST_BAD_PC;
        else begin wr = 1; wr_idx = 6'd1; wr_val = nxt; nxt = t; end
      end
      OP_RET: nxt = rd_reg(6'd1);
      OP_HALT: st = ST_HALT;
      OP_SYSCALL: sys = 1;
      default: st = ST_BAD_OP;
    endcase
    if (st != ST_OK) begin
      if (commit) begin
        halted = 1;
        halt_st = st;
      end
      o.st = st;
      o.pc = cpu_pc;
      return o;
    end
    if (commit) begin
      if (do_st) begin
        v = rd_reg(r.rb);
        for (int i = 0; i < 8; i++) dmem[a + i] = v[8*i +: 8];
      end
      if (wr && wr_idx != 0) regs[wr_idx] = wr_val;
      cpu_pc = nxt;
      retired++;
    end
    o.st = ST_OK;
    o.pc = nxt;
    o.sys = sys;
    o.num = sys ? r.imm : 64'd0;
    return o;
  endfunction

  function automatic instr_req_t mk(logic [3:0] op, logic [5:0] rd, logic [5:0] ra,
                                    logic [5:0] rb, logic [63:0] imm);
    instr_req_t r;
    r.op = op; r.rd = rd; r.ra = ra; r.rb = rb; r.imm = imm;
    return r;
  endfunction

  function automatic instr_req_t any_instr();
    return mk($urandom_range(15), $urandom_range(63), $urandom_range(63),
              $urandom_range(63), {$urandom, $urandom});
  endfunction

  function automatic instr_req_t program_instr();
    instr_req_t  r;
    int unsigned sel, sz, addr;
    r = any_instr();
    r.op = OP_NOP;
    sel = $urandom_range(99);
    sz = (cfg_dbu > MEMSZ) ? MEMSZ : cfg_dbu;
    if (sel < 20) begin
      r.op = OP_LI;
      r.rd = $urandom_range(31);
      if ($urandom_range(1)) r.imm = $urandom_range(8191);
    end else if (sel < 35) begin
      r.op = $urandom_range(1) ? OP_ADD : OP_XOR;
      r.rd = $urandom_range(31); r.ra = $urandom_range(31); r.rb = $urandom_range(31);
    end else if (sel < 60) begin
      r.op = $urandom_range(1) ? OP_LD : OP_ST;
      r.rd = $urandom_range(31); r.ra = $urandom_range(31); r.rb = $urandom_range(31);
      addr = (sz >= 8) ? $urandom_range(sz - 8) : 0;
      if ($urandom_range(3) == 0) r.ra = 0;
      r.imm = 64'(addr) - rd_reg(r.ra);
    end else if (sel < 75) begin
      r.op = ($urandom_range(2) == 0) ? OP_J : ($urandom_range(1) ? OP_BEQ : OP_CALL);
      r.ra = $urandom_range(31);
      r.rb = $urandom_range(1) ? r.ra : 6'($urandom_range(31));
      r.imm = 64'(8 * ($signed($urandom_range(40)) - 20));
    end else if (sel < 80) begin
      r.op = OP_RET;
    end else if (sel < 88) begin
      r.op = OP_SYSCALL;
    end
    return r;
  endfunction

  task automatic issue(instr_req_t r);
    if (!no_idle && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_i <= r.op;
    dest_reg_i <= r.rd;
    src_reg_a_i <= r.ra;
    src_reg_b_i <= r.rb;
    immediate_i <= r.imm;
    do @(posedge clk); while (!in_ready_o);
    results_q = {results_q, execute(r, 1'b1)};
    n_sent++;
  endtask

  task automatic issue_program(int n);
    instr_req_t r;
    outcome_t   o;
    repeat (n) begin
      for (int k = 0; k < 10; k++) begin
        r = program_instr();
        o = execute(r, 1'b0);
        if (o.st == ST_OK) break;
        r = mk(OP_NOP, $urandom_range(63), $urandom_range(63), $urandom_range(63),
               {$urandom, $urandom});
      end
      issue(r);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      CFG_ENTRY_PC: begin
        cfg_entry = val;
        if (retired == 0 && !halted) cpu_pc = val;
      end
      CFG_STEP_LIMIT: cfg_limit = val[31:0];
      CFG_DATA_BYTES: cfg_dbu = val[12:0];
      default: ;
    endcase
  endtask

  task automatic test_directed();
    instr_req_t d [$];
    cfg_write(CFG_ENTRY_PC, 64'hFFFF_FFFF_FFFF_FFF0);
    d = {d, mk(OP_NOP, 63, 63, 63, 0)};
    d = {d, mk(OP_NOP, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF)};
    d = {d, mk(OP_LI, 5, 63, 63, 64'h8000_0000_0000_0001)};
    d = {d, mk(OP_LI, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF)};
    d = {d, mk(OP_LI, 31, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF)};
    d = {d, mk(OP_ADD, 6, 5, 31, 0)};
    d = {d, mk(OP_XOR, 7, 5, 31, 0)};
    d = {d, mk(OP_ADD, 2, 0, 5, 0)};
    d = {d, mk(OP_ST, 63, 0, 7, 64'd4088)};
    d = {d, mk(OP_LD, 8, 0, 63, 64'd4088)};
    d = {d, mk(OP_ST, 0, 0, 5, 0)};
    d = {d, mk(OP_LI, 10, 0, 0, 64'd100)};
    d = {d, mk(OP_LD, 11, 10, 0, -64'sd100)};
    d = {d, mk(OP_J, 63, 63, 63, 64'd16)};
    d = {d, mk(OP_BEQ, 0, 0, 0, 64'd8)};
    d = {d, mk(OP_BEQ, 0, 5, 0, 64'd8)};
    d = {d, mk(OP_CALL, 40, 50, 60, 64'd24)};
    d = {d, mk(OP_RET, 33, 34, 35, 0)};
    d = {d, mk(OP_SYSCALL, 63, 63, 63, 64'h8000_0000_0000_0000)};
    d = {d, mk(OP_SYSCALL, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF)};
    d = {d, mk(OP_NOP, 0, 0, 0, 0)};
    foreach (d[i]) issue(d[i]);
    drain();
    cfg_write(CFG_ENTRY_PC, 64'd0);
  endtask

  task automatic test_random_flow(int n);
    issue_program(n);
    drain();
  endtask

  task automatic test_no_idle(int n);
    no_idle = 1;
    issue_program(n);
    no_idle = 0;
    drain();
  endtask

  task automatic test_backpressure(int n);
    fork
      begin
        hold_rx = 1;
        repeat (150) @(posedge clk);
        hold_rx = 0;
      end
    join_none
    issue_program(n);
    drain();
  endtask

  task automatic test_data_bounds();
    cfg_write(CFG_STEP_LIMIT, 64'(retired) + 100000);
    cfg_write(CFG_DATA_BYTES, 64'd0);
    test_random_flow(60);
    cfg_write(CFG_DATA_BYTES, 64'd8191);
    test_random_flow(80);
    cfg_write(CFG_DATA_BYTES, 64'($urandom_range(8, 4096)));
    cfg_write(CFG_STEP_LIMIT, 64'hFFFF_FFFF);
    cfg_write(CFG_ENTRY_PC, 64'hFFFF_FFFF_FFFF_FFFF);
    test_random_flow(120);
    cfg_write(CFG_DATA_BYTES, 64'd4096);
  endtask

  task automatic test_trap();
    instr_req_t r;
    outcome_t   o;
    n_trap_kind = $urandom_range(5);
    r = mk(OP_NOP, $urandom_range(63), $urandom_range(63), $urandom_range(63), 0);
    case (n_trap_kind)
      0: cfg_write(CFG_STEP_LIMIT, 64'(retired));
      1: r.op = OP_HALT;
      2: r.op = $urandom_range(12, 15);
      3: begin r.op = OP_LI; r.rd = $urandom_range(32, 63); end
      4: begin r = mk(OP_LD, 1, 0, 0, -64'sd8); end
      default: begin
        r.op = OP_J;
        r.imm = 64'h8000_0000_0000_0000;
        o = execute(r, 1'b0);
        if (o.st == ST_OK) r.imm = 64'h7FFF_FFFF_FFFF_FFFF;
      end
    endcase
    issue(r);
    repeat (14) issue(any_instr());
    issue(mk(OP_HALT, 0, 0, 0, 0));
    drain();
  endtask

  task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result %0d: expected %h, got %h", what, n_checked,
               exp_v, act_v);
  endtask

  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_rx && (no_idle || $urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_ni && out_valid_o && out_ready) begin
      if (results_q.size() == 0) begin
        report("unexpected result pc", 64'd0, pc_out_o);
      end else begin
        e = results_q.pop_front();
        if (status_o != e.st) report("status", 64'(e.st), 64'(status_o));
        if (pc_out_o != e.pc) report("pc_out", e.pc, pc_out_o);
        if (syscall_seen_o != e.sys) report("syscall_seen", 64'(e.sys), 64'(syscall_seen_o));
        if (syscall_number_o != e.num) report("syscall_number", e.num, syscall_number_o);
        if (e.sys) n_sys++;
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("timeout: no request moved for %0d cycles", WATCHDOG);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    cpu_pc = '0;
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    retired = '0;
    halted = 0;
    halt_st = ST_OK;
    cfg_entry = '0;
    cfg_limit = 32'hFFFF_FFFF;
    cfg_dbu = 13'd4096;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_flow(150);
    test_no_idle(80);
    test_backpressure(40);
    test_data_bounds();
    test_trap();
    repeat (10) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d syscalls, %0d instructions retired",
             n_sent, n_checked, n_sys, retired);
    $display("config sweeps over entry pc, step limit and memory size; final trap kind %0d",
             n_trap_kind);
    if (mismatches == 0 && results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, results_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
